// ===== sv/dgbs_pkg.sv =====
// Shared types and constants for the dominant gravity body selector.
`timescale 1ns / 1ps
package dgbs_pkg;

  localparam logic CFG_STAR_INDEX = 1'b0;
  localparam logic CFG_TWO_G      = 1'b1;

  localparam logic [13:0] ENERGY_SCALE = 14'd10000;

  typedef struct packed {
    logic [7:0]  cand;
    logic [51:0] cmass;
    logic [35:0] px;
    logic [35:0] py;
    logic [35:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        qual;
    logic        last;
  } dgbs_item_t;

  typedef struct packed {
    logic       start;
    logic       accum;
    logic [2:0] a_last;
    logic [1:0] b_last;
  } dgbs_mul_ctl_t;

endpackage

// ===== sv/dgbs_front.sv =====
// Front end: screens each candidate request and forms position and velocity magnitudes.
`timescale 1ns / 1ps
module dgbs_front import dgbs_pkg::*; #(
  parameter int unsigned MAX_BODIES = 256
) (
  input  logic [7:0]   star_index,
  input  logic [7:0]   subject_index,
  input  logic [51:0]  subject_mass,
  input  logic [7:0]   candidate_index,
  input  logic [51:0]  candidate_mass,
  input  logic [35:0]  pos_x,
  input  logic [35:0]  pos_y,
  input  logic [35:0]  pos_z,
  input  logic [31:0]  vel_x,
  input  logic [31:0]  vel_y,
  input  logic [31:0]  vel_z,
  input  logic         last_candidate,
  output dgbs_item_t   item
);

  always_comb begin
    item.cand  = candidate_index;
    item.cmass = candidate_mass;
    item.px    = pos_x[35] ? 36'(-pos_x) : pos_x;
    item.py    = pos_y[35] ? 36'(-pos_y) : pos_y;
    item.pz    = pos_z[35] ? 36'(-pos_z) : pos_z;
    item.vx    = vel_x[31] ? 32'(-vel_x) : vel_x;
    item.vy    = vel_y[31] ? 32'(-vel_y) : vel_y;
    item.vz    = vel_z[31] ? 32'(-vel_z) : vel_z;
    item.qual  = (subject_index != star_index) && (candidate_index != subject_index) &&
                 (candidate_index != star_index) && (32'(candidate_index) < MAX_BODIES) &&
                 (candidate_mass > subject_mass);
    item.last  = last_candidate;
  end

endmodule

// ===== sv/dgbs_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module dgbs_queue import dgbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dgbs_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output dgbs_item_t q_item
);

  dgbs_item_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/dgbs_mul.sv =====
// Limb-serial wide multiplier: one 32x32 partial product per cycle into a 256-bit sum.
`timescale 1ns / 1ps
module dgbs_mul import dgbs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dgbs_mul_ctl_t ctl,
  input  logic [255:0]  a,
  input  logic [95:0]   b,
  output logic          done,
  output logic [255:0]  acc
);

  logic         run_r;
  logic [2:0]   i_r;
  logic [1:0]   j_r;
  logic [2:0]   a_last_r;
  logic [1:0]   b_last_r;
  logic [63:0]  prod_r;
  logic [3:0]   off_r;
  logic         pv_r;
  logic         plast_r;
  logic         done_r;
  logic [255:0] acc_r;
  logic [31:0]  a_limb;
  logic [31:0]  b_limb;
  logic         launch;

  assign a_limb = a[{i_r, 5'b0} +: 32];
  assign b_limb = b[{j_r, 5'b0} +: 32];
  assign launch = ctl.start && !run_r;
  assign done   = done_r;
  assign acc    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      i_r      <= 3'd0;
      j_r      <= 2'd0;
      a_last_r <= 3'd0;
      b_last_r <= 2'd0;
      pv_r     <= 1'b0;
      plast_r  <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r  <= pv_r && plast_r;
      pv_r    <= run_r;
      plast_r <= (i_r == a_last_r) && (j_r == b_last_r);
      if (launch) begin
        run_r    <= 1'b1;
        i_r      <= 3'd0;
        j_r      <= 2'd0;
        a_last_r <= ctl.a_last;
        b_last_r <= ctl.b_last;
      end else if (run_r) begin
        if (j_r == b_last_r) begin
          j_r <= 2'd0;
          if (i_r == a_last_r) begin
            run_r <= 1'b0;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end else begin
          j_r <= j_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_limb * b_limb;
    off_r  <= {1'b0, i_r} + {2'b0, j_r};
    if (launch && !ctl.accum) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ({192'b0, prod_r} << {off_r, 5'b0});
    end
  end

endmodule

// ===== sv/dgbs_back.sv =====
// Back end: sequences the energy and force products and tracks the best candidate.
`timescale 1ns / 1ps
module dgbs_back import dgbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  star_index,
  input  logic [19:0] two_g_scaled,
  input  logic        q_valid,
  input  dgbs_item_t  q_item,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_index,
  output logic        out_found
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RX   = 4'd1;
  localparam logic [3:0] ST_RY   = 4'd2;
  localparam logic [3:0] ST_RZ   = 4'd3;
  localparam logic [3:0] ST_VX   = 4'd4;
  localparam logic [3:0] ST_VY   = 4'd5;
  localparam logic [3:0] ST_VZ   = 4'd6;
  localparam logic [3:0] ST_V4   = 4'd7;
  localparam logic [3:0] ST_T    = 4'd8;
  localparam logic [3:0] ST_L    = 4'd9;
  localparam logic [3:0] ST_KM   = 4'd10;
  localparam logic [3:0] ST_RHS  = 4'd11;
  localparam logic [3:0] ST_C1   = 4'd12;
  localparam logic [3:0] ST_C2   = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  logic [3:0]    state_r;
  logic          go_r;
  dgbs_item_t    itm_r;
  logic [71:0]   r2_r;
  logic [63:0]   v2_r;
  logic [127:0]  v4_r;
  logic [199:0]  t_r;
  logic [213:0]  lhs_r;
  logic [71:0]   km_r;
  logic [123:0]  p1_r;
  logic          any_r;
  logic [7:0]    best_idx_r;
  logic [51:0]   best_mass_r;
  logic [71:0]   best_d_r;
  logic          out_valid_r;
  logic [7:0]    out_index_r;
  logic          out_found_r;

  dgbs_mul_ctl_t mctl;
  logic [255:0]  ma;
  logic [95:0]   mb;
  logic          mdone;
  logic [255:0]  macc;
  logic          in_mul;
  logic          bound;
  logic          update;

  assign in_mul    = (state_r != ST_IDLE) && (state_r != ST_FIN);
  assign pop       = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_found = out_found_r;
  assign bound     = (r2_r != 72'd0) && (lhs_r < {70'b0, macc[143:0]});
  assign update    = mdone && (((state_r == ST_RHS) && bound && !any_r) ||
                     ((state_r == ST_C2) && (p1_r > macc[123:0])));

  always_comb begin
    ma          = '0;
    mb          = '0;
    mctl.accum  = 1'b0;
    mctl.a_last = 3'd0;
    mctl.b_last = 2'd0;
    mctl.start  = in_mul && !go_r;
    unique case (state_r)
      ST_RX, ST_RY, ST_RZ: begin
        mctl.accum  = (state_r != ST_RX);
        mctl.a_last = 3'd1;
        mctl.b_last = 2'd1;
        ma = {220'b0, (state_r == ST_RX) ? itm_r.px : (state_r == ST_RY) ? itm_r.py : itm_r.pz};
        mb = {60'b0, (state_r == ST_RX) ? itm_r.px : (state_r == ST_RY) ? itm_r.py : itm_r.pz};
      end
      ST_VX, ST_VY, ST_VZ: begin
        mctl.accum = (state_r != ST_VX);
        ma = {224'b0, (state_r == ST_VX) ? itm_r.vx : (state_r == ST_VY) ? itm_r.vy : itm_r.vz};
        mb = {64'b0, (state_r == ST_VX) ? itm_r.vx : (state_r == ST_VY) ? itm_r.vy : itm_r.vz};
      end
      ST_V4: begin
        ma = {192'b0, v2_r};
        mb = {32'b0, v2_r};
        mctl.a_last = 3'd1;
        mctl.b_last = 2'd1;
      end
      ST_T: begin
        ma = {128'b0, v4_r};
        mb = {24'b0, r2_r};
        mctl.a_last = 3'd3;
        mctl.b_last = 2'd2;
      end
      ST_L: begin
        ma = {56'b0, t_r};
        mb = {82'b0, ENERGY_SCALE};
        mctl.a_last = 3'd6;
      end
      ST_KM: begin
        ma = {204'b0, itm_r.cmass};
        mb = {76'b0, two_g_scaled};
        mctl.a_last = 3'd1;
      end
      ST_RHS: begin
        ma = {184'b0, km_r};
        mb = {24'b0, km_r};
        mctl.a_last = 3'd2;
        mctl.b_last = 2'd2;
      end
      ST_C1: begin
        ma = {204'b0, itm_r.cmass};
        mb = {24'b0, best_d_r};
        mctl.a_last = 3'd1;
        mctl.b_last = 2'd2;
      end
      ST_C2: begin
        ma = {204'b0, best_mass_r};
        mb = {24'b0, r2_r};
        mctl.a_last = 3'd1;
        mctl.b_last = 2'd2;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  dgbs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .acc   (macc)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      itm_r <= q_item;
    end
    if (mdone) begin
      case (state_r)
        ST_RZ:   r2_r  <= macc[71:0];
        ST_VZ:   v2_r  <= macc[63:0];
        ST_V4:   v4_r  <= macc[127:0];
        ST_T:    t_r   <= macc[199:0];
        ST_L:    lhs_r <= macc[213:0];
        ST_KM:   km_r  <= macc[71:0];
        ST_C1:   p1_r  <= macc[123:0];
        default: ;
      endcase
    end
    if (update) begin
      best_idx_r  <= itm_r.cand;
      best_mass_r <= itm_r.cmass;
      best_d_r    <= r2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_index_r <= 8'd0;
      out_found_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !((state_r == ST_FIN) && itm_r.last)) begin
        out_valid_r <= 1'b0;
      end
      if (update) begin
        any_r <= 1'b1;
      end
      if (mctl.start) begin
        go_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= q_item.qual ? ST_RX : ST_FIN;
          end
        end
        ST_FIN: begin
          if (!itm_r.last) begin
            state_r <= ST_IDLE;
          end else if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_index_r <= any_r ? best_idx_r : star_index;
            out_found_r <= any_r;
            any_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          if (mdone) begin
            go_r <= 1'b0;
            case (state_r)
              ST_RHS:  state_r <= (bound && any_r) ? ST_C1 : ST_FIN;
              ST_C2:   state_r <= ST_FIN;
              default: state_r <= state_r + 4'd1;
            endcase
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/dominant_gravity_body_select_core.sv =====
// Top level: picks the dominant gravity body over a stream of candidate requests.
// A screened-out request goes straight to the finish state, where a last request gives its result;
// a qualified request runs a bound test as a chain of limb-serial 32x32 multiplies (r^2, v^2, v^4,
// the energy product, its scaling, the mass term and its square), plus two cross products when
// compared with an earlier winner. The back end takes a new request only once it is idle again;
// two more requests wait in the queue, and a last request holds while the output is full.
// Reset (rst_n, synchronous): star_index 0, two_g_scaled 13348, queue and query state cleared.
`timescale 1ns / 1ps
module dominant_gravity_body_select_core import dgbs_pkg::*; #(
  parameter int unsigned MAX_BODIES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // subject_index, subject_mass, candidate_index, candidate_mass, pos_x, pos_y, pos_z,
  // vel_x, vel_y, vel_z, zero fill
  input  logic [327:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reference_index
  output logic [7:0]   out_tdata,
  // found_bound
  output logic         out_tuser
);

  logic [7:0]  star_r;
  logic [19:0] two_g_r;
  dgbs_item_t  f_item;
  dgbs_item_t  q_item;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  logic        push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      star_r  <= 8'd0;
      two_g_r <= 20'd13348;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STAR_INDEX: star_r  <= cfg_wdata[7:0];
        CFG_TWO_G:      two_g_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  dgbs_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .star_index      (star_r),
    .subject_index   (in_tdata[7:0]),
    .subject_mass    (in_tdata[59:8]),
    .candidate_index (in_tdata[67:60]),
    .candidate_mass  (in_tdata[119:68]),
    .pos_x           (in_tdata[155:120]),
    .pos_y           (in_tdata[191:156]),
    .pos_z           (in_tdata[227:192]),
    .vel_x           (in_tdata[259:228]),
    .vel_y           (in_tdata[291:260]),
    .vel_z           (in_tdata[323:292]),
    .last_candidate  (in_tlast),
    .item            (f_item)
  );

  dgbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  dgbs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .star_index   (star_r),
    .two_g_scaled (two_g_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_index    (out_tdata),
    .out_found    (out_tuser)
  );

endmodule
